// ===== sv/mbs_pkg.sv =====
// Package for the multipart boundary splitter.
// Holds the shared types, character codes, command slot layout and helpers.
// No dependencies.
package mbs_pkg;

    // Boundary and configuration sizes
    localparam int MAX_BOUNDARY_BYTES = 16;
    localparam int LEN_W              = 5;
    localparam int CFG_DATA_W         = 64;
    localparam int CFG_INDEX_W        = 2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_BND_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BND_HIGH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BND_LEN  = 2'd2;

    // Character codes
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_DASH = 8'h2D;

    // Command slot layout: one bit per possible result of one byte, in order
    localparam int CMD_SLOTS  = 20;
    localparam int SLOT_W     = 5;
    localparam int POS_CR     = 0;
    localparam int POS_LF     = 1;
    localparam int POS_DASH0  = 2;
    localparam int POS_DASH1  = 3;
    localparam int POS_BND0   = 4;
    localparam int POS_BND_LAST = POS_BND0 + MAX_BOUNDARY_BYTES - 2;
    localparam int POS_FINAL  = 19;

    // Command queue depth
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_CONTENT = 2'd0,
        KIND_PART    = 2'd1,
        KIND_CLOSE   = 2'd2
    } kind_t;

    // Line scanner states
    typedef enum logic [3:0] {
        ST_LINE_START     = 4'd0,
        ST_ONE_DASH       = 4'd1,
        ST_MATCHING       = 4'd2,
        ST_OPEN_TAIL      = 4'd3,
        ST_OPEN_TAIL_CR   = 4'd4,
        ST_AFTER_BND_DASH = 4'd5,
        ST_CLOSE_TAIL     = 4'd6,
        ST_CLOSE_TAIL_CR  = 4'd7,
        ST_BODY           = 4'd8,
        ST_BODY_CR        = 4'd9
    } state_t;

    // Boundary configuration
    typedef struct packed {
        logic [CFG_DATA_W-1:0] bnd_low;
        logic [CFG_DATA_W-1:0] bnd_high;
        logic [LEN_W-1:0]      bnd_len;
    } cfg_t;

    // One classified input byte: which results it causes
    typedef struct packed {
        logic [CMD_SLOTS-1:0] mask;
        logic [7:0]           data;
        kind_t                kind;
    } cmd_t;

    // Boundary byte at index idx
    function automatic logic [7:0] bnd_byte(input cfg_t cfg, input logic [3:0] idx);
        logic [2*CFG_DATA_W-1:0] bytes;
        bytes = {cfg.bnd_high, cfg.bnd_low};
        return bytes[{idx, 3'b000} +: 8];
    endfunction

endpackage

// ===== sv/mbs_front.sv =====
// Front part of the multipart boundary splitter: line scanner.
// Classifies each accepted byte into a result command. Depends on mbs_pkg.
module mbs_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    in_byte,
    input  mbs_pkg::cfg_t cfg,
    output logic          cmd_push,
    output mbs_pkg::cmd_t cmd
);

    mbs_pkg::state_t       state_reg, state_next;
    logic                  held_reg, held_next;
    logic [mbs_pkg::LEN_W-1:0] mcount_reg, mcount_next;
    logic                  open_reg, open_next;

    logic                  give_up;
    logic [mbs_pkg::LEN_W-1:0] extra;
    logic                  plain_b;
    logic                  cr_out;
    logic                  marker;
    mbs_pkg::kind_t        kind;
    logic [mbs_pkg::LEN_W-1:0] eff_len;
    logic                  is_cr, is_lf, is_dash;

    // Effective boundary length, clamped to the maximum
    assign eff_len = (cfg.bnd_len > mbs_pkg::LEN_W'(mbs_pkg::MAX_BOUNDARY_BYTES))
                     ? mbs_pkg::LEN_W'(mbs_pkg::MAX_BOUNDARY_BYTES) : cfg.bnd_len;
    assign is_cr   = (in_byte == mbs_pkg::CH_CR);
    assign is_lf   = (in_byte == mbs_pkg::CH_LF);
    assign is_dash = (in_byte == mbs_pkg::CH_DASH);

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= mbs_pkg::ST_LINE_START;
            held_reg   <= 1'b0;
            mcount_reg <= '0;
            open_reg   <= 1'b0;
        end
        else if (accept)
        begin
            state_reg  <= state_next;
            held_reg   <= held_next;
            mcount_reg <= mcount_next;
            open_reg   <= open_next;
        end
    end

    // Next state and classification
    always_comb
    begin
        state_next  = state_reg;
        held_next   = held_reg;
        mcount_next = mcount_reg;
        open_next   = open_reg;
        give_up     = 1'b0;
        extra       = '0;
        plain_b     = 1'b0;
        cr_out      = 1'b0;
        marker      = 1'b0;
        kind        = mbs_pkg::KIND_CONTENT;
        case (state_reg)
            mbs_pkg::ST_LINE_START:
            begin
                if (is_dash)
                    state_next = mbs_pkg::ST_ONE_DASH;
                else
                    give_up = 1'b1;
            end
            mbs_pkg::ST_ONE_DASH:
            begin
                if (is_dash)
                begin
                    state_next  = mbs_pkg::ST_MATCHING;
                    mcount_next = '0;
                end
                else
                begin
                    give_up = 1'b1;
                    extra   = mbs_pkg::LEN_W'(1);
                end
            end
            mbs_pkg::ST_MATCHING:
            begin
                if (mcount_reg < eff_len)
                begin
                    if (in_byte == mbs_pkg::bnd_byte(cfg, mcount_reg[3:0]))
                        mcount_next = mcount_reg + 1'b1;
                    else
                    begin
                        give_up = 1'b1;
                        extra   = mcount_reg + mbs_pkg::LEN_W'(2);
                    end
                end
                else if (is_dash)
                    state_next = mbs_pkg::ST_AFTER_BND_DASH;
                else
                    state_next = is_cr ? mbs_pkg::ST_OPEN_TAIL_CR : mbs_pkg::ST_OPEN_TAIL;
            end
            mbs_pkg::ST_OPEN_TAIL:
            begin
                state_next = is_cr ? mbs_pkg::ST_OPEN_TAIL_CR : mbs_pkg::ST_OPEN_TAIL;
            end
            mbs_pkg::ST_OPEN_TAIL_CR:
            begin
                if (is_lf)
                begin
                    state_next  = mbs_pkg::ST_LINE_START;
                    held_next   = 1'b0;
                    mcount_next = '0;
                    open_next   = 1'b1;
                    marker      = 1'b1;
                    kind        = mbs_pkg::KIND_PART;
                end
                else
                    state_next = is_cr ? mbs_pkg::ST_OPEN_TAIL_CR : mbs_pkg::ST_OPEN_TAIL;
            end
            mbs_pkg::ST_AFTER_BND_DASH:
            begin
                if (is_dash)
                    state_next = mbs_pkg::ST_CLOSE_TAIL;
                else
                    state_next = is_cr ? mbs_pkg::ST_OPEN_TAIL_CR : mbs_pkg::ST_OPEN_TAIL;
            end
            mbs_pkg::ST_CLOSE_TAIL:
            begin
                state_next = is_cr ? mbs_pkg::ST_CLOSE_TAIL_CR : mbs_pkg::ST_CLOSE_TAIL;
            end
            mbs_pkg::ST_CLOSE_TAIL_CR:
            begin
                if (is_lf)
                begin
                    state_next  = mbs_pkg::ST_LINE_START;
                    held_next   = 1'b0;
                    mcount_next = '0;
                    open_next   = 1'b0;
                    marker      = 1'b1;
                    kind        = mbs_pkg::KIND_CLOSE;
                end
                else
                    state_next = is_cr ? mbs_pkg::ST_CLOSE_TAIL_CR : mbs_pkg::ST_CLOSE_TAIL;
            end
            mbs_pkg::ST_BODY_CR:
            begin
                if (is_lf)
                begin
                    state_next = mbs_pkg::ST_LINE_START;
                    held_next  = 1'b1;
                end
                else
                begin
                    cr_out  = 1'b1;
                    plain_b = 1'b1;
                end
            end
            default:
            begin
                plain_b = 1'b1;
            end
        endcase

        // Failed match: drop the held CRLF flag, then handle the byte as body
        if (give_up)
        begin
            held_next = 1'b0;
            plain_b   = 1'b1;
        end
        if (plain_b)
            state_next = is_cr ? mbs_pkg::ST_BODY_CR : mbs_pkg::ST_BODY;
    end

    // Result mask: content slots only while a part is open, markers always
    always_comb
    begin
        cmd.mask = '0;
        cmd.mask[mbs_pkg::POS_CR] = open_reg && ((give_up && held_reg) || cr_out);
        cmd.mask[mbs_pkg::POS_LF] = open_reg && give_up && held_reg;
        for (int p = mbs_pkg::POS_DASH0; p <= mbs_pkg::POS_BND_LAST; p++)
        begin
            cmd.mask[p] = open_reg && give_up && (extra >= mbs_pkg::LEN_W'(p - 1));
        end
        cmd.mask[mbs_pkg::POS_FINAL] = marker || (open_reg && plain_b && !is_cr);
        cmd.data = in_byte;
        cmd.kind = kind;
    end

    assign cmd_push = accept && (|cmd.mask);

endmodule

// ===== sv/mbs_cmd_fifo.sv =====
// Command queue between scanner and result expander.
// Small register queue of result commands. Depends on mbs_pkg.
module mbs_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mbs_pkg::cmd_t push_cmd,
    input  logic          pop,
    output mbs_pkg::cmd_t head_cmd,
    output logic          fifo_empty,
    output logic          fifo_full
);

    mbs_pkg::cmd_t store [mbs_pkg::FIFO_DEPTH];
    logic [mbs_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [mbs_pkg::FIFO_CNT_W-1:0] count_reg, count_next;

    assign fifo_empty = (count_reg == '0);
    assign fifo_full  = (count_reg == mbs_pkg::FIFO_CNT_W'(mbs_pkg::FIFO_DEPTH));
    assign head_cmd   = store[rd_ptr_reg];

    // Occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    // Pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            store[wr_ptr_reg] <= push_cmd;
    end

endmodule

// ===== sv/mbs_back.sv =====
// Back part of the multipart boundary splitter: result expander.
// Walks each command's slot mask one result per cycle into an output register,
// as long as that register is empty or being popped. Depends on mbs_pkg.
module mbs_back (
    input  logic          clk,
    input  logic          rst_n,
    input  mbs_pkg::cfg_t cfg,
    input  mbs_pkg::cmd_t head_cmd,
    input  logic          fifo_empty,
    output logic          fifo_pop,
    input  logic          pop,
    output logic          empty,
    output logic [7:0]    out_byte,
    output logic [1:0]    out_kind,
    output logic          last
);

    logic [mbs_pkg::CMD_SLOTS-1:0] mask_reg, mask_next;
    logic [7:0]                    data_reg;
    mbs_pkg::kind_t                kind_reg;
    logic                          cur_valid_reg, cur_valid_next;

    logic                          out_valid_reg;
    logic [7:0]                    out_byte_reg;
    logic [1:0]                    out_kind_reg;
    logic                          out_last_reg;

    logic                          out_ready, emit, cur_done, load;
    logic [mbs_pkg::CMD_SLOTS-1:0] low_bit, rest;
    logic [mbs_pkg::SLOT_W-1:0]    slot;
    logic [7:0]                    slot_byte;
    logic [1:0]                    slot_kind;
    logic [3:0]                    bnd_idx;

    // Handshake between expander and output register
    assign out_ready = !out_valid_reg || pop;
    assign emit      = cur_valid_reg && out_ready;
    assign low_bit   = mask_reg & (~mask_reg + 1'b1);
    assign rest      = mask_reg & ~low_bit;
    assign cur_done  = emit && (rest == '0);
    assign load      = (!cur_valid_reg || cur_done) && !fifo_empty;
    assign fifo_pop  = load;

    // Slot number of the lowest pending result
    always_comb
    begin
        slot = '0;
        for (int p = 0; p < mbs_pkg::CMD_SLOTS; p++)
        begin
            if (low_bit[p])
                slot = slot | mbs_pkg::SLOT_W'(p);
        end
    end

    // Result value for the slot
    assign bnd_idx = 4'(slot - mbs_pkg::SLOT_W'(mbs_pkg::POS_BND0));
    always_comb
    begin
        slot_kind = mbs_pkg::KIND_CONTENT;
        case (slot)
            mbs_pkg::SLOT_W'(mbs_pkg::POS_CR):    slot_byte = mbs_pkg::CH_CR;
            mbs_pkg::SLOT_W'(mbs_pkg::POS_LF):    slot_byte = mbs_pkg::CH_LF;
            mbs_pkg::SLOT_W'(mbs_pkg::POS_DASH0): slot_byte = mbs_pkg::CH_DASH;
            mbs_pkg::SLOT_W'(mbs_pkg::POS_DASH1): slot_byte = mbs_pkg::CH_DASH;
            mbs_pkg::SLOT_W'(mbs_pkg::POS_FINAL):
            begin
                slot_kind = kind_reg;
                slot_byte = (kind_reg == mbs_pkg::KIND_CONTENT) ? data_reg : 8'h00;
            end
            default:                              slot_byte = mbs_pkg::bnd_byte(cfg, bnd_idx);
        endcase
    end

    // Current command tracking
    always_comb
    begin
        mask_next      = mask_reg;
        cur_valid_next = cur_valid_reg;
        if (emit)
        begin
            mask_next = rest;
            if (cur_done)
                cur_valid_next = 1'b0;
        end
        if (load)
        begin
            mask_next      = head_cmd.mask;
            cur_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        mask_reg <= mask_next;
        if (load)
        begin
            data_reg <= head_cmd.data;
            kind_reg <= head_cmd.kind;
        end
        if (emit)
        begin
            out_byte_reg <= slot_byte;
            out_kind_reg <= slot_kind;
            out_last_reg <= (rest == '0);
        end
    end

    assign empty    = !out_valid_reg;
    assign out_byte = out_byte_reg;
    assign out_kind = out_kind_reg;
    assign last     = out_last_reg;

endmodule

// ===== sv/multipart_boundary_splitter_top.sv =====
// Top level of the multipart boundary splitter.
// Holds the boundary registers and joins scanner, command queue and expander.
// Depends on mbs_pkg, mbs_front, mbs_cmd_fifo, mbs_back.

// The splitter takes one body byte per cycle on push/full and hands out one
// result item per cycle on empty/pop. The scanner classifies each byte in the
// cycle it is accepted; a byte that causes N result items (up to 20, when a
// failed boundary match replays the held CRLF and matched prefix) occupies
// the result expander until all N are emitted; a four-entry command queue
// between them absorbs such bursts, and full rises only when it is full.
// Bytes with no result (preamble, epilogue, delimiter lines before their LF)
// never enter the queue. Results pass the mask and output registers in turn.
// Write the boundary registers only while the block is idle.
module multipart_boundary_splitter_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [7:0]                        in_byte,
    input  logic                              pop,
    output logic                              empty,
    output logic [7:0]                        out_byte,
    output logic [1:0]                        out_kind,
    output logic                              last,
    input  logic                              cfg_we,
    input  logic [mbs_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mbs_pkg::CFG_DATA_W-1:0]    cfg_data
);

    mbs_pkg::cfg_t cfg_reg;
    mbs_pkg::cmd_t push_cmd, head_cmd;
    logic          accept, cmd_push, fifo_pop, fifo_empty, fifo_full;

    // Boundary registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bnd_low  <= '0;
            cfg_reg.bnd_high <= '0;
            cfg_reg.bnd_len  <= mbs_pkg::LEN_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mbs_pkg::REG_BND_LOW:  cfg_reg.bnd_low  <= cfg_data;
                mbs_pkg::REG_BND_HIGH: cfg_reg.bnd_high <= cfg_data;
                mbs_pkg::REG_BND_LEN:  cfg_reg.bnd_len  <= cfg_data[mbs_pkg::LEN_W-1:0];
                default:               ;
            endcase
        end
    end

    assign full   = fifo_full;
    assign accept = push && !fifo_full;

    mbs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .in_byte  (in_byte),
        .cfg      (cfg_reg),
        .cmd_push (cmd_push),
        .cmd      (push_cmd)
    );

    mbs_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (cmd_push),
        .push_cmd   (push_cmd),
        .pop        (fifo_pop),
        .head_cmd   (head_cmd),
        .fifo_empty (fifo_empty),
        .fifo_full  (fifo_full)
    );

    mbs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_cmd   (head_cmd),
        .fifo_empty (fifo_empty),
        .fifo_pop   (fifo_pop),
        .pop        (pop),
        .empty      (empty),
        .out_byte   (out_byte),
        .out_kind   (out_kind),
        .last       (last)
    );

endmodule
